@@ rtl/core/sha1_byte_stream_hasher_macros.svh @@
// sha1_byte_stream_hasher_macros.svh: assertion macros shared by the hasher rtl
// no dependencies; taken in by the files that carry concurrent assertions
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH

// same-cycle implication, reset masks the check
`define SHA1BSH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define SHA1BSH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sha1bsh_pkg.sv @@
// sha1bsh_pkg: types, constants and round functions of the sha-1 byte stream hasher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sha1bsh_pkg;

  localparam int unsigned RoundsPerBlock = 80;
  localparam int unsigned BlockBytes     = 64;
  localparam int unsigned LenPos         = 56;
  localparam int unsigned CntW           = $clog2(RoundsPerBlock);
  localparam int unsigned FillW          = $clog2(BlockBytes);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [4:0][31:0]  chain_t;
  typedef logic [15:0][31:0] window_t;

  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    STG_CH,
    STG_PAR1,
    STG_MAJ,
    STG_PAR2
  } stage_e;

  // strobes from the sequencer to the window and the round unit
  typedef struct packed {
    logic       byte_shift;
    logic [7:0] byte_val;
    logic       sched_shift;
    logic       vars_load;
    logic       vars_step;
    stage_e     stage;
    logic       chain_add;
    logic       chain_init;
  } ctl_t;

  function automatic logic [31:0] sha1_k(stage_e stg);
    logic [31:0] k;
    case (stg)
      STG_CH:   k = 32'h5A827999;
      STG_PAR1: k = 32'h6ED9EBA1;
      STG_MAJ:  k = 32'h8F1BBCDC;
      STG_PAR2: k = 32'hCA62C1D6;
      default:  k = 32'h5A827999;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] sha1_f(stage_e stg, logic [31:0] b, logic [31:0] c,
                                         logic [31:0] d);
    logic [31:0] f;
    case (stg)
      STG_CH:  f = (b & c) | (~b & d);
      STG_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha1bsh_in_if.sv @@
// sha1bsh_in_if: valid/ready channel carrying one message byte transaction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sha1bsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sha1bsh_out_if.sv @@
// sha1bsh_out_if: valid/ready channel carrying one digest transaction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sha1bsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;
  logic [63:0] short_hash;
  logic        length_error;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, short_hash, length_error, input ready);
  modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, short_hash, length_error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sha1bsh_sched.sv @@
// sha1bsh_sched: 16-word message window, byte-wise fill and per-round schedule shift
// depends on sha1bsh_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha1bsh_sched (
  input  logic                clk_i,
  input  sha1bsh_pkg::ctl_t   ctl_i,
  output logic [31:0]         w_o
);
  import sha1bsh_pkg::*;

  window_t     win_q, win_d;
  logic [31:0] w_mix;

  // next schedule word, w[t+16] from the taps of the window
  assign w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];

  always_comb begin
    win_d = win_q;
    if (ctl_i.byte_shift) begin
      // byte fill: the whole window moves one byte toward word 0
      for (int i = 0; i < 15; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[15] = {win_q[15][23:0], ctl_i.byte_val};
    end else if (ctl_i.sched_shift) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = {w_mix[30:0], w_mix[31]};
    end
  end

  // window registers hold payload only
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o = win_q[0];

endmodule

`default_nettype wire

@@ rtl/core/sha1bsh_round.sv @@
// sha1bsh_round: shared sha-1 round unit with working variables and chaining words
// depends on sha1bsh_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha1bsh_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha1bsh_pkg::ctl_t    ctl_i,
  input  logic [31:0]          w_i,
  output sha1bsh_pkg::chain_t  chain_o
);
  import sha1bsh_pkg::*;

  chain_t      vars_q, vars_d;
  chain_t      chain_q, chain_d;
  logic [31:0] sum;

  // one round: rotl(a,5) + f + e + w + k
  assign sum = {vars_q[0][26:0], vars_q[0][31:27]}
             + sha1_f(ctl_i.stage, vars_q[1], vars_q[2], vars_q[3])
             + vars_q[4] + w_i + sha1_k(ctl_i.stage);

  always_comb begin
    vars_d = vars_q;
    if (ctl_i.vars_load) begin
      vars_d = chain_q;
    end else if (ctl_i.vars_step) begin
      vars_d[4] = vars_q[3];
      vars_d[3] = vars_q[2];
      vars_d[2] = {vars_q[1][1:0], vars_q[1][31:2]};
      vars_d[1] = vars_q[0];
      vars_d[0] = sum;
    end
  end

  // chaining words: add after a block, back to init after a digest leaves
  always_comb begin
    chain_d = chain_q;
    if (ctl_i.chain_init) begin
      chain_d = H_INIT;
    end else if (ctl_i.chain_add) begin
      for (int i = 0; i < 5; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= H_INIT;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

`default_nettype wire

@@ rtl/core/sha1bsh_ctrl.sv @@
// sha1bsh_ctrl: sequencer for byte intake, padding, rounds and digest hand-off
// depends on sha1bsh_pkg and sha1_byte_stream_hasher_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_byte_stream_hasher_macros.svh"

module sha1bsh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_present_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               length_error_o,
  output sha1bsh_pkg::ctl_t  ctl_o
);
  import sha1bsh_pkg::*;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [63:0]      bc_q, bc_d;
  logic [63:0]      bc_add;
  logic             ovf_q, ovf_d;
  logic             finishing_q, finishing_d;
  logic             pad_first_q, pad_first_d;
  logic             tail_zero_q, tail_zero_d;
  logic             pad_done_q, pad_done_d;
  logic             take, wrap, fill_last, in_len_zone;
  logic [7:0]       len_byte;

  localparam logic [FillW-1:0] FillLast = FillW'(BlockBytes - 1);
  localparam logic [FillW-1:0] FillLen  = FillW'(LenPos);
  localparam logic [CntW-1:0]  CntLast  = CntW'(RoundsPerBlock - 1);

  assign take        = byte_present_i && !ovf_q;
  assign bc_add      = bc_q + 64'd8;
  assign fill_last   = (fill_q == FillLast);
  assign wrap        = take && fill_last;
  assign in_len_zone = (fill_q >= FillLen);
  // big-endian length byte for positions 56..63
  assign len_byte    = 8'(bc_q >> {~fill_q[2:0], 3'b000});

  // next state and strobes
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    bc_d        = bc_q;
    ovf_d       = ovf_q;
    finishing_d = finishing_q;
    pad_first_d = pad_first_q;
    tail_zero_d = tail_zero_q;
    pad_done_d  = pad_done_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    ctl_o.stage = STG_CH;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (take) begin
            ctl_o.byte_shift = 1'b1;
            ctl_o.byte_val   = data_byte_i;
            fill_d           = fill_q + 1'b1;
            bc_d             = bc_add;
            if (bc_add == 64'd0) begin
              ovf_d = 1'b1;
            end
          end
          if (last_byte_i && ovf_d) begin
            state_d = ST_OUT;
          end else begin
            if (last_byte_i) begin
              finishing_d = 1'b1;
              pad_first_d = 1'b1;
              pad_done_d  = 1'b0;
              tail_zero_d = 1'b0;
              state_d     = ST_PAD;
            end
            if (wrap) begin
              ctl_o.vars_load = 1'b1;
              cnt_d           = '0;
              state_d         = ST_ROUND;
            end
          end
        end
      end

      ST_PAD: begin
        // one pad, fill or length byte per cycle
        ctl_o.byte_shift = 1'b1;
        fill_d           = fill_q + 1'b1;
        if (pad_first_q) begin
          ctl_o.byte_val = PAD_BYTE;
          pad_first_d    = 1'b0;
          tail_zero_d    = in_len_zone;
        end else if (in_len_zone && !tail_zero_q) begin
          ctl_o.byte_val = len_byte;
          if (fill_last) begin
            pad_done_d = 1'b1;
          end
        end else begin
          ctl_o.byte_val = 8'h00;
        end
        if (fill_last) begin
          tail_zero_d     = 1'b0;
          ctl_o.vars_load = 1'b1;
          cnt_d           = '0;
          state_d         = ST_ROUND;
        end
      end

      ST_ROUND: begin
        ctl_o.vars_step   = 1'b1;
        ctl_o.sched_shift = 1'b1;
        if (cnt_q < CntW'(20)) begin
          ctl_o.stage = STG_CH;
        end else if (cnt_q < CntW'(40)) begin
          ctl_o.stage = STG_PAR1;
        end else if (cnt_q < CntW'(60)) begin
          ctl_o.stage = STG_MAJ;
        end else begin
          ctl_o.stage = STG_PAR2;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        ctl_o.chain_add = 1'b1;
        if (!finishing_q) begin
          state_d = ST_IDLE;
        end else if (pad_done_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end

      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctl_o.chain_init = 1'b1;
          fill_d           = '0;
          bc_d             = '0;
          ovf_d            = 1'b0;
          finishing_d      = 1'b0;
          pad_first_d      = 1'b0;
          tail_zero_d      = 1'b0;
          pad_done_d       = 1'b0;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      bc_q        <= '0;
      ovf_q       <= 1'b0;
      finishing_q <= 1'b0;
      pad_first_q <= 1'b0;
      tail_zero_q <= 1'b0;
      pad_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      bc_q        <= bc_d;
      ovf_q       <= ovf_d;
      finishing_q <= finishing_d;
      pad_first_q <= pad_first_d;
      tail_zero_q <= tail_zero_d;
      pad_done_q  <= pad_done_d;
    end
  end

  assign length_error_o = ovf_q;

  // checks
  `SHA1BSH_ASSERT_IMP(a_no_intake_while_out, clk_i, rst_ni, out_valid_o, !in_ready_o, "input ready while digest pending")
  `SHA1BSH_ASSERT_IMP(a_round_in_range, clk_i, rst_ni, state_q == ST_ROUND, cnt_q <= CntLast, "round counter out of range")
  `SHA1BSH_ASSERT_NXT(a_clear_after_out, clk_i, rst_ni, out_valid_o && out_ready_i, (fill_q == '0) && (bc_q == '0) && !ovf_q, "message state not cleared after digest")
  `SHA1BSH_ASSERT_IMP(a_done_only_final, clk_i, rst_ni, pad_done_q, finishing_q, "length block finished outside a message end")

endmodule

`default_nettype wire

@@ rtl/core/sha1_byte_stream_hasher.sv @@
// SHA-1 byte stream hasher. A message arrives one byte per input transaction; a
// transaction with last_byte set ends it and produces one digest transaction. Bytes
// are taken at one per cycle while the input is ready. Every 64th byte starts a
// compression (80 rounds on one shared round adder, then the chaining update) during
// which the input is not ready. At the end of a message the pad, zero fill and length
// bytes are shifted in at one per cycle, then compressed, with a second final block
// when the length no longer fits, before the digest is offered. The digest is held
// until taken; no new byte is accepted meanwhile. In a sustained stream the pace is
// set by the single round unit, as no byte is taken during a compression. On length
// overflow the digest reads as zero with length_error set.
// depends on sha1bsh_pkg, sha1bsh_in_if, sha1bsh_out_if, sha1bsh_ctrl, sha1bsh_sched,
// sha1bsh_round
`timescale 1ns / 1ps
`default_nettype none

module sha1_byte_stream_hasher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sha1bsh_in_if.sink           msg_i,
  sha1bsh_out_if.source        dig_o
);
  import sha1bsh_pkg::*;

  ctl_t        ctl;
  chain_t      chain;
  logic [31:0] w;
  logic        len_err;

  sha1bsh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (msg_i.valid),
    .in_ready_o     (msg_i.ready),
    .data_byte_i    (msg_i.data_byte),
    .byte_present_i (msg_i.byte_present),
    .last_byte_i    (msg_i.last_byte),
    .out_valid_o    (dig_o.valid),
    .out_ready_i    (dig_o.ready),
    .length_error_o (len_err),
    .ctl_o          (ctl)
  );

  sha1bsh_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (w)
  );

  sha1bsh_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .w_i     (w),
    .chain_o (chain)
  );

  // digest words read straight from the chaining registers, zeroed on overflow
  assign dig_o.digest_word0 = len_err ? 32'd0 : chain[0];
  assign dig_o.digest_word1 = len_err ? 32'd0 : chain[1];
  assign dig_o.digest_word2 = len_err ? 32'd0 : chain[2];
  assign dig_o.digest_word3 = len_err ? 32'd0 : chain[3];
  assign dig_o.digest_word4 = len_err ? 32'd0 : chain[4];
  assign dig_o.short_hash   = len_err ? 64'd0 : {chain[0], chain[1]};
  assign dig_o.length_error = len_err;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for sha1_byte_stream_hasher, random and directed byte streams
// keeps its own sha-1 digest predictor; needs sha1bsh_in_if, sha1bsh_out_if and the rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TotalItems  = 1900;
  localparam int unsigned IdlePercent = 38;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned TailCycles  = 300;

  localparam logic [4:0][31:0] CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                             32'hEFCDAB89, 32'h67452301};
  localparam logic [3:0][31:0] ROUND_K    = {32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1,
                                             32'h5A827999};
  localparam logic [7:0]       PAD_MARK   = 8'h80;

  typedef struct {
    logic [4:0][31:0] words;
    logic [63:0]      short_hash;
    logic             length_error;
  } digest_t;

  logic clk_i;
  logic rst_ni;

  sha1bsh_in_if  msg_if ();
  sha1bsh_out_if dig_if ();

  sha1_byte_stream_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  // predictor state
  logic [7:0]       msg_blk [64];
  int unsigned      blk_fill;
  logic [4:0][31:0] chain;
  logic [63:0]      msg_bits;
  bit               len_ovf;

  digest_t     expected_digests [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned bytes_sent;
  int unsigned msgs_sent;
  int unsigned digests_checked;
  bit          send_idle_en;
  bit          recv_idle_en;
  bit          hold_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void hash_restart();
    chain    = CHAIN_INIT;
    blk_fill = 0;
    msg_bits = '0;
    len_ovf  = 1'b0;
  endfunction

  function automatic void hash_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, sum;
    int          t;
    for (t = 0; t < 16; t++) begin
      w[t] = {msg_blk[4*t], msg_blk[4*t+1], msg_blk[4*t+2], msg_blk[4*t+3]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (t = 0; t < 80; t++) begin
      // message schedule kept as a 16-word sliding window
      if (t >= 16) begin
        sum = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
        w[t & 15] = {sum[30:0], sum[31]};
      end
      if (t < 20) f = (b & c) | (~b & d);
      else if (t >= 40 && t < 60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      sum = {a[26:0], a[31:27]} + f + e + w[t & 15] + ROUND_K[t / 20];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  // pad byte, zero fill and big-endian bit length, one or two final blocks
  function automatic void hash_finish();
    int unsigned idx;
    idx = blk_fill;
    msg_blk[idx] = PAD_MARK;
    idx++;
    if (idx > 56) begin
      while (idx < 64) begin
        msg_blk[idx] = 8'h00;
        idx++;
      end
      hash_compress();
      idx = 0;
    end
    while (idx < 56) begin
      msg_blk[idx] = 8'h00;
      idx++;
    end
    for (int k = 0; k < 8; k++) msg_blk[56 + k] = msg_bits[63 - 8*k -: 8];
    hash_compress();
  endfunction

  // apply one accepted transaction, queue a digest when the message ends
  function automatic void hash_absorb(logic [7:0] data, logic present, logic last);
    digest_t res;
    if (present && !len_ovf) begin
      msg_blk[blk_fill] = data;
      blk_fill = (blk_fill + 1) % 64;
      msg_bits = msg_bits + 64'd8;
      if (msg_bits == '0) len_ovf = 1'b1;
      if (blk_fill == 0) hash_compress();
    end
    if (last) begin
      if (len_ovf) begin
        res.words        = '0;
        res.short_hash   = '0;
        res.length_error = 1'b1;
      end else begin
        hash_finish();
        res.words        = chain;
        res.short_hash   = {chain[0], chain[1]};
        res.length_error = 1'b0;
      end
      expected_digests.push_back(res);
      hash_restart();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // offer one transaction; entered and left at a falling edge
  task automatic send_item(input logic [7:0] data, input logic present, input logic last);
    while (send_idle_en && $urandom_range(0, 99) < IdlePercent) begin
      msg_if.valid = 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid        = 1'b1;
    msg_if.data_byte    = data;
    msg_if.byte_present = present;
    msg_if.last_byte    = last;
    do @(posedge clk_i); while (!msg_if.ready);
    hash_absorb(data, present, last);
    if (present || last) items_sent++;
    if (present) bytes_sent++;
    @(negedge clk_i);
  endtask

  // random message bytes, now and then a no-op transaction in between
  task automatic send_message(input int unsigned nbytes, input bit end_on_byte);
    for (int unsigned i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 99) < 6) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == nbytes - 1));
    end
    if (!end_on_byte || nbytes == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    msgs_sent++;
  endtask

  task automatic wait_drained();
    msg_if.valid = 1'b0;
    while (expected_digests.size() != 0) @(negedge clk_i);
  endtask

  // short messages mostly, block boundaries often, a few long ones
  function automatic int unsigned pick_msg_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom_range(0, 20);
    if (sel < 75) begin
      case ($urandom_range(0, 9))
        0:       return 55;
        1:       return 56;
        2:       return 57;
        3:       return 63;
        4:       return 64;
        5:       return 65;
        6:       return 119;
        7:       return 120;
        8:       return 127;
        default: return 128;
      endcase
    end
    if (sel < 95) return $urandom_range(21, 130);
    return $urandom_range(131, 200);
  endfunction

  // digest receiver: random ready, or a long counted hold-off on request
  initial begin
    dig_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        dig_if.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        dig_if.ready = !(recv_idle_en && $urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    digest_t got;
    digest_t exp;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      got.words        = {dig_if.digest_word4, dig_if.digest_word3, dig_if.digest_word2,
                          dig_if.digest_word1, dig_if.digest_word0};
      got.short_hash   = dig_if.short_hash;
      got.length_error = dig_if.length_error;
      if (expected_digests.size() == 0) begin
        $error("unexpected digest transaction, digest_word0 %h", got.words[0]);
        mismatches++;
      end else begin
        exp = expected_digests.pop_front();
        digests_checked++;
        for (int i = 0; i < 5; i++) begin
          if (got.words[i] !== exp.words[i]) begin
            $error("digest_word%0d: expected %h, got %h", i, exp.words[i], got.words[i]);
            mismatches++;
          end
        end
        if (got.short_hash !== exp.short_hash) begin
          $error("short_hash: expected %h, got %h", exp.short_hash, got.short_hash);
          mismatches++;
        end
        if (got.length_error !== exp.length_error) begin
          $error("length_error: expected %b, got %b", exp.length_error, got.length_error);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // empty message, "abc", extreme bytes, no-op transaction, end without a byte
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    msgs_sent += 5;
    wait_drained();
  endtask

  // receiver stalls long enough that the block backs up onto its input
  task automatic test_output_hold();
    hold_req = 1'b1;
    repeat (6) send_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // back-to-back traffic on both sides
  task automatic test_full_rate();
    int unsigned stop_at;
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    stop_at = items_sent + 300;
    while (items_sent < stop_at) send_message(pick_msg_len(), 1'($urandom_range(0, 1)));
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // bulk random messages, sender pauses for a full drain now and then
  task automatic test_random_messages();
    int unsigned n;
    n = 0;
    while (items_sent < TotalItems) begin
      send_message(pick_msg_len(), 1'($urandom_range(0, 1)));
      n++;
      if (n % 9 == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_ni              = 1'b0;
    msg_if.valid        = 1'b0;
    msg_if.data_byte    = 8'h00;
    msg_if.byte_present = 1'b0;
    msg_if.last_byte    = 1'b0;
    send_idle_en        = 1'b1;
    recv_idle_en        = 1'b1;
    hold_req            = 1'b0;
    mismatches          = 0;
    items_sent          = 0;
    bytes_sent          = 0;
    msgs_sent           = 0;
    digests_checked     = 0;
    hash_restart();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_output_hold();
    test_full_rate();
    test_random_messages();

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    $display("covered %0d messages, %0d bytes in %0d transactions, %0d digests checked",
             msgs_sent, bytes_sent, items_sent, digests_checked);
    $display("with empty messages, block-boundary lengths, output hold-off and drains");
    if (mismatches == 0 && expected_digests.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sha1_byte_stream_hasher.f @@
+incdir+rtl/core
rtl/core/sha1bsh_pkg.sv
rtl/core/sha1bsh_in_if.sv
rtl/core/sha1bsh_out_if.sv
rtl/core/sha1bsh_sched.sv
rtl/core/sha1bsh_round.sv
rtl/core/sha1bsh_ctrl.sv
rtl/core/sha1_byte_stream_hasher.sv
bench/tb_top.sv
